// File: sv/sdf_pkg.sv
// Shared character codes and bits per stage for the signed decimal formatter.
package sdf_pkg;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam int BitsPerStage = 4;
endpackage

// File: sv/sdf_conv.sv
// Pipelined binary to BCD conversion with digit count.
module sdf_conv #(
  parameter int VB  = 32,
  parameter int ND  = 10,
  parameter int NDW = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [31:0]     value_i,
  input  logic [5:0]      field_width_i,
  input  logic            pad_with_zeros_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [4*ND-1:0] digits_o,
  output logic [NDW-1:0]  ndig_o,
  output logic            neg_o,
  output logic [5:0]      width_o,
  output logic            zeros_o
);
  localparam int NST = (VB + sdf_pkg::BitsPerStage - 1) / sdf_pkg::BitsPerStage;

  logic [NST:0]      v_q;
  logic [NST+1:0]    rdy;
  logic [VB-1:0]     mag_q [NST+1];
  logic [4*ND-1:0]   bcd_q [NST+1];
  logic [NST:0]      neg_q;
  logic [5:0]        wid_q [NST+1];
  logic [NST:0]      zer_q;

  logic [63:0]       ext;
  logic [VB-1:0]     raw;
  logic [VB-1:0]     mag_d;

  // count stage
  logic              cv_q;
  logic [4*ND-1:0]   cdig_q;
  logic [NDW-1:0]    ccnt_q;
  logic [NDW-1:0]    ccnt_d;
  logic              cneg_q;
  logic [5:0]        cwid_q;
  logic              czer_q;

  assign ext   = {{32{value_i[31]}}, value_i};
  assign raw   = ext[VB-1:0];
  assign mag_d = raw[VB-1] ? (~raw + 1'b1) : raw;

  assign rdy[NST+1] = !cv_q || !out_stall_i;
  assign rdy[0]     = !v_q[0] || rdy[1];
  assign in_stall_o = !rdy[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (rdy[0]) begin
      v_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0] && in_valid_i) begin
      mag_q[0] <= mag_d;
      bcd_q[0] <= '0;
      neg_q[0] <= raw[VB-1];
      wid_q[0] <= field_width_i;
      zer_q[0] <= pad_with_zeros_i;
    end
  end

  for (genvar s = 1; s <= NST; s++) begin : g_stage
    localparam int LO = (s - 1) * sdf_pkg::BitsPerStage;
    localparam int NB = (VB - LO < sdf_pkg::BitsPerStage) ? VB - LO : sdf_pkg::BitsPerStage;
    logic [4*ND-1:0] b;
    logic [VB-1:0]   m;

    if (s == NST) begin : g_last
      assign rdy[s] = !v_q[s] || rdy[NST+1];
    end else begin : g_mid
      assign rdy[s] = !v_q[s] || rdy[s+1];
    end

    // shift-and-add-3 over this stage's slice of bits
    always_comb begin
      b = bcd_q[s-1];
      m = mag_q[s-1];
      for (int j = 0; j < NB; j++) begin
        for (int d = 0; d < ND; d++) begin
          if (b[4*d +: 4] >= 4'd5) b[4*d +: 4] = b[4*d +: 4] + 4'd3;
        end
        b = {b[4*ND-2:0], m[VB-1]};
        m = m << 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_q[s] <= v_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && v_q[s-1]) begin
        mag_q[s] <= m;
        bcd_q[s] <= b;
        neg_q[s] <= neg_q[s-1];
        wid_q[s] <= wid_q[s-1];
        zer_q[s] <= zer_q[s-1];
      end
    end
  end

  always_comb begin
    ccnt_d = NDW'(1);
    for (int d = 0; d < ND; d++) begin
      if (bcd_q[NST][4*d +: 4] != 4'd0) ccnt_d = NDW'(d + 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q <= 1'b0;
    end else if (rdy[NST+1]) begin
      cv_q <= v_q[NST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NST+1] && v_q[NST]) begin
      cdig_q <= bcd_q[NST];
      ccnt_q <= ccnt_d;
      cneg_q <= neg_q[NST];
      cwid_q <= wid_q[NST];
      czer_q <= zer_q[NST];
    end
  end

  assign out_valid_o = cv_q;
  assign digits_o    = cdig_q;
  assign ndig_o      = ccnt_q;
  assign neg_o       = cneg_q;
  assign width_o     = cwid_q;
  assign zeros_o     = czer_q;
endmodule

// File: sv/sdf_emit.sv
// Character serializer: padding, sign and digits, one character per cycle unless stalled.
module sdf_emit #(
  parameter int ND  = 10,
  parameter int NDW = 4,
  parameter int WL  = 63
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [4*ND-1:0] digits_i,
  input  logic [NDW-1:0]  ndig_i,
  input  logic            neg_i,
  input  logic [5:0]      width_i,
  input  logic            zeros_i,
  output logic            valid_o,
  input  logic            stall_i,
  output logic [7:0]      char_out_o,
  output logic            last_char_o
);
  logic            busy_q;
  logic [4*ND-1:0] dig_q;
  logic            neg_q;
  logic            zer_q;
  logic [6:0]      padn_q;
  logic [6:0]      total_q;
  logic [6:0]      p_q;
  logic            ov_q;
  logic [7:0]      char_q;
  logic            last_q;

  logic [5:0]      ws;
  logic [6:0]      tl;
  logic [6:0]      total_d;
  logic [6:0]      didx;
  logic [3:0]      dsel;
  logic [7:0]      ch;
  logic            is_last;
  logic            adv;

  assign ws      = (width_i > 6'(WL)) ? 6'(WL) : width_i;
  assign tl      = 7'(ndig_i) + 7'(neg_i);
  assign total_d = ({1'b0, ws} > tl) ? {1'b0, ws} : tl;

  assign didx    = total_q - 7'd1 - p_q;
  assign is_last = (p_q == total_q - 7'd1);
  assign adv     = busy_q && (!ov_q || !stall_i);
  assign in_stall_o = busy_q;

  always_comb begin
    dsel = 4'd0;
    for (int d = 0; d < ND; d++) begin
      if (didx == 7'(d)) dsel = dig_q[4*d +: 4];
    end
    if (zer_q) begin
      if (neg_q && p_q == 7'd0)           ch = sdf_pkg::CharMinus;
      else if (p_q < padn_q + 7'(neg_q))  ch = sdf_pkg::CharZero;
      else                                ch = sdf_pkg::CharZero + 8'(dsel);
    end else begin
      if (p_q < padn_q)                   ch = sdf_pkg::CharSpace;
      else if (neg_q && p_q == padn_q)    ch = sdf_pkg::CharMinus;
      else                                ch = sdf_pkg::CharZero + 8'(dsel);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
      p_q    <= '0;
    end else begin
      if (adv) begin
        ov_q <= 1'b1;
        p_q  <= p_q + 7'd1;
        if (is_last) busy_q <= 1'b0;
      end else if (ov_q && !stall_i) begin
        ov_q <= 1'b0;
      end
      if (!busy_q && in_valid_i) begin
        busy_q <= 1'b1;
        p_q    <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q && in_valid_i) begin
      dig_q   <= digits_i;
      neg_q   <= neg_i;
      zer_q   <= zeros_i;
      total_q <= total_d;
      padn_q  <= total_d - tl;
    end
    if (adv) begin
      char_q <= ch;
      last_q <= is_last;
    end
  end

  assign valid_o     = ov_q;
  assign char_out_o  = char_q;
  assign last_char_o = last_q;
endmodule

// File: sv/signed_decimal_formatter_padded_unit.sv
// Top level: signed integer to padded ASCII decimal text.
// Conversion pipeline takes a request every cycle unless stalled; the
// serializer sends one character per cycle unless stalled, with
// max(text length, width) characters per request.
// Reset (rst_ni low, asynchronous) clears all valid and busy flags.
module signed_decimal_formatter_padded_unit #(
  parameter int VALUE_BITS  = 32,
  parameter int WIDTH_LIMIT = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] value_i,
  input  logic [5:0]  field_width_i,
  input  logic        pad_with_zeros_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [7:0]  char_out_o,
  output logic        last_char_o
);
  localparam int ND  = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int NDW = $clog2(ND + 1);

  logic            c_valid;
  logic            c_stall;
  logic [4*ND-1:0] c_digits;
  logic [NDW-1:0]  c_ndig;
  logic            c_neg;
  logic [5:0]      c_width;
  logic            c_zeros;

  sdf_conv #(.VB(VALUE_BITS), .ND(ND), .NDW(NDW)) u_conv (
    .clk_i, .rst_ni,
    .in_valid_i(valid_i), .in_stall_o(stall_o),
    .value_i, .field_width_i, .pad_with_zeros_i,
    .out_valid_o(c_valid), .out_stall_i(c_stall),
    .digits_o(c_digits), .ndig_o(c_ndig), .neg_o(c_neg),
    .width_o(c_width), .zeros_o(c_zeros)
  );

  sdf_emit #(.ND(ND), .NDW(NDW), .WL(WIDTH_LIMIT)) u_emit (
    .clk_i, .rst_ni,
    .in_valid_i(c_valid), .in_stall_o(c_stall),
    .digits_i(c_digits), .ndig_i(c_ndig), .neg_i(c_neg),
    .width_i(c_width), .zeros_i(c_zeros),
    .valid_o, .stall_i, .char_out_o, .last_char_o
  );
endmodule

// File: tb/signed_decimal_formatter_padded_unit_tb.sv
// Testbench for the signed decimal formatter: directed table, then random requests.
module signed_decimal_formatter_padded_unit_tb;

  typedef struct {
    logic [31:0] value;
    logic [5:0]  width;
    logic        zeros;
    string       text;  // expected text typed in, "" means use the predictor
  } req_row_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } char_t;

  localparam int WatchdogLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [31:0] value_i = '0;
  logic [5:0]  field_width_i = '0;
  logic        pad_with_zeros_i = 1'b0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [7:0]  char_out_o;
  logic        last_char_o;

  char_t expected_chars[$];
  int    errors = 0;
  int    idle_cycles = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  bit    hold_off = 1'b0;

  signed_decimal_formatter_padded_unit i_dut (
    .clk_i, .rst_ni, .valid_i, .stall_o, .value_i, .field_width_i,
    .pad_with_zeros_i, .valid_o, .stall_i, .char_out_o, .last_char_o
  );

  always #5 clk_i = ~clk_i;

  // Decimal text of one request, padding included.
  function automatic string format_decimal(logic [31:0] value, logic [5:0] width,
                                           logic zeros);
    logic [31:0] mag;
    string digits, pad, sign;
    int    text_len;
    begin
      digits = "";
      pad = "";
      sign = value[31] ? "-" : "";
      mag = value[31] ? -value : value;
      if (mag == 0) digits = "0";
      while (mag != 0) begin
        digits = {string'(8'(sdf_pkg::CharZero + mag % 10)), digits};
        mag = mag / 10;
      end
      text_len = digits.len() + sign.len();
      for (int i = text_len; i < width; i++) pad = {pad, zeros ? "0" : " "};
      return zeros ? {sign, pad, digits} : {pad, sign, digits};
    end
  endfunction

  task automatic push_text(string text);
    char_t c;
    begin
      for (int i = 0; i < text.len(); i++) begin
        c.ch = text[i];
        c.last = (i == text.len() - 1);
        expected_chars.push_back(c);
      end
    end
  endtask

  task automatic send_request(logic [31:0] value, logic [5:0] width, logic zeros,
                              string typed);
    string text;
    begin
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
        valid_i <= 1'b0;
        @(posedge clk_i);
      end
      valid_i <= 1'b1;
      value_i <= value;
      field_width_i <= width;
      pad_with_zeros_i <= zeros;
      text = format_decimal(value, width, zeros);
      if (typed != "" && typed != text) begin
        $display("%0t table/predictor disagree: expected \"%s\" actual \"%s\"",
                 $time, typed, text);
        errors++;
      end
      push_text(typed != "" ? typed : text);
      do @(posedge clk_i); while (stall_o);
    end
  endtask

  // Receiver stall and checking.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      idle_cycles <= 0;
      if (expected_chars.size() == 0) begin
        $display("%0t unexpected char: expected none actual %h last %b",
                 $time, char_out_o, last_char_o);
        errors++;
      end else begin
        if (expected_chars[0].ch !== char_out_o || expected_chars[0].last !== last_char_o) begin
          $display("%0t mismatch: expected %h last %b actual %h last %b", $time,
                   expected_chars[0].ch, expected_chars[0].last, char_out_o, last_char_o);
          errors++;
        end
        void'(expected_chars.pop_front());
      end
    end else if (rst_ni && !(valid_i && !stall_o)) begin
      idle_cycles <= idle_cycles + 1;
    end
    stall_i <= hold_off || (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WatchdogLimit) begin
      $display("signed_decimal_formatter_padded_unit_tb failed");
      $finish;
    end
  end

  task automatic send_random(int count);
    logic [31:0] v;
    logic [5:0]  w;
    begin
      repeat (count) begin
        case ($urandom_range(3))
          0: v = $urandom;
          1: v = $urandom_range(999);
          2: v = -$urandom_range(99999);
          default: v = $urandom >> $urandom_range(31);
        endcase
        w = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(14));
        send_request(v, w, 1'($urandom), "");
      end
    end
  endtask

  req_row_t directed[] = '{
    '{32'd0, 6'd0, 1'b0, "0"},
    '{32'd0, 6'd3, 1'b1, "000"},
    '{32'd0, 6'd3, 1'b0, "  0"},
    '{32'h8000_0000, 6'd0, 1'b0, "-2147483648"},
    '{32'h8000_0000, 6'd13, 1'b1, "-002147483648"},
    '{32'h7FFF_FFFF, 6'd0, 1'b0, "2147483647"},
    '{32'hFFFF_FFFF, 6'd0, 1'b0, "-1"},
    '{-32'sd5, 6'd4, 1'b1, "-005"},
    '{-32'sd5, 6'd4, 1'b0, "  -5"},
    '{32'd123, 6'd2, 1'b1, "123"},
    '{32'd123, 6'd3, 1'b0, "123"},
    '{32'd7, 6'd63, 1'b1, ""},
    '{32'h8000_0000, 6'd63, 1'b0, ""},
    '{32'd1000000000, 6'd11, 1'b0, ""},
    '{32'h5555_AAAA, 6'd21, 1'b1, ""},
    '{32'hAAAA_5555, 6'd42, 1'b0, ""}
  };

  task automatic drain;
    begin
      while (expected_chars.size() != 0) @(posedge clk_i);
      repeat (20) @(posedge clk_i);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i])
      send_request(directed[i].value, directed[i].width, directed[i].zeros, directed[i].text);
    send_random(120);
    send_idle_pct = 64;
    send_random(80);
    send_idle_pct = 0;
    recv_stall_pct = 64;
    send_random(80);
    send_idle_pct = 14;
    recv_stall_pct = 14;
    send_random(80);
    // sender waits for all requests to finish
    valid_i <= 1'b0;
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        send_random(60);
        valid_i <= 1'b0;
      end
    join
    drain();
    if (errors == 0) $display("signed_decimal_formatter_padded_unit_tb passed");
    else $display("signed_decimal_formatter_padded_unit_tb failed");
    $finish;
  end
endmodule
